// ===== rtl/ahct_pkg.sv =====
// ----------------------------------------------------------------------------
// ahct_pkg
// Shared types and constants of the aging hash cache table: command and
// status codes, slot marks, the stored entry and the controller/datapath link.
// ----------------------------------------------------------------------------
package ahct_pkg;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_LOOKUP = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_CLEAR  = 3'd4,
    CMD_EVICT  = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_HIT       = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    MARK_EMPTY    = 2'd0,
    MARK_OCCUPIED = 2'd1,
    MARK_DELETED  = 2'd2
  } mark_e;

  typedef struct packed {
    mark_e       mark;
    logic [63:0] key;
    logic [63:0] used;
  } entry_t;

  localparam logic [63:0] HASH_MUL1  = 64'hff51afd7ed558ccd;
  localparam logic [63:0] HASH_MUL2  = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned HASH_SHIFT = 33;

  localparam logic [8:0]  ENTRY_LIMIT_RST = 9'd256;
  localparam logic [8:0]  ENTRY_LIMIT_DEF = 9'd256;
  localparam logic [15:0] AGE_LIMIT_RST   = 16'd120;

  localparam logic CFG_ENTRY_LIMIT = 1'b0;
  localparam logic CFG_AGE_LIMIT   = 1'b1;

  typedef struct packed {
    logic load_in;
    logic frame_inc;
    logic hash_start;
    logic idx_zero;
    logic idx_home;
    logic idx_step;
    logic age_ins;
    logic wr_clr;
    logic wr_touch;
    logic wr_del_cur;
    logic wr_ins;
    logic wr_del_pick;
    logic live_clr;
    logic set_nf;
    logic set_full;
    logic old_init;
    logic old_upd;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic hash_done;
    logic is_empty;
    logic is_occ;
    logic key_match;
    logic aged;
    logic older;
    logic idx_last;
    logic cnt_last;
    logic at_limit;
    logic over_limit;
    logic pick_vld;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/ahct_hash.sv =====
// ----------------------------------------------------------------------------
// ahct_hash
// Multi-cycle 64-bit murmur finalizer built around one 32x32 multiplier.
// ----------------------------------------------------------------------------
module ahct_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] key_i,
  output logic        done_o,
  output logic [63:0] hash_o
);
  import ahct_pkg::*;

  logic [63:0] h_q, acc_q, sum, c;
  logic [31:0] a, b;
  logic [63:0] prod;
  logic        busy_q, ph_q, done_q;
  logic [1:0]  sub_q;

  // Each 64-bit product keeps only its low half: three partial products.
  always_comb begin
    c = ph_q ? HASH_MUL2 : HASH_MUL1;
    a = (sub_q == 2'd2) ? h_q[63:32] : h_q[31:0];
    b = (sub_q == 2'd1) ? c[63:32] : c[31:0];
    prod = a * b;
    if (sub_q == 2'd0) begin
      sum = prod;
    end else begin
      sum = acc_q + {prod[31:0], 32'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q    <= '0;
      acc_q  <= '0;
      busy_q <= 1'b0;
      ph_q   <= 1'b0;
      sub_q  <= 2'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        h_q    <= key_i ^ (key_i >> HASH_SHIFT);
        busy_q <= 1'b1;
        ph_q   <= 1'b0;
        sub_q  <= 2'd0;
      end else if (busy_q) begin
        acc_q <= sum;
        case (sub_q)
          2'd2: begin
            h_q   <= sum ^ (sum >> HASH_SHIFT);
            sub_q <= 2'd0;
            if (ph_q) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end else begin
              ph_q <= 1'b1;
            end
          end
          default: sub_q <= sub_q + 2'd1;
        endcase
      end
    end
  end

  assign done_o = done_q;
  assign hash_o = h_q;

endmodule

// ===== rtl/ahct_dp.sv =====
// ----------------------------------------------------------------------------
// ahct_dp
// Datapath: slot memory, counters, frame, configuration and result register.
// ----------------------------------------------------------------------------
module ahct_dp #(
  parameter int unsigned CAPACITY = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ahct_pkg::dp_cmd_t cmd_i,
  output ahct_pkg::dp_stat_t stat_o,
  input  logic [63:0]       key_i,
  input  logic [63:0]       age_limit_i,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [2:0]        status_o,
  output logic [8:0]        slot_index_o,
  output logic [9:0]        entry_count_o,
  output logic [63:0]       frame_number_o
);
  import ahct_pkg::*;

  localparam int unsigned IW   = $clog2(CAPACITY);
  localparam int unsigned CW   = IW + 1;
  localparam int unsigned CmpW = (CW > 10) ? CW : 10;
  localparam int unsigned WW   = (IW > 9) ? IW : 9;

  entry_t      mem [CAPACITY];
  entry_t      rd_q, wd;
  logic [IW-1:0] idx_q, cnt_q, pick_q, wa;
  logic [CW-1:0] live_q, live_dec;
  logic [63:0] frame_q, key_q, age_q, oldest_q, hash;
  logic        pick_vld_q, hash_done, wr_en;
  logic [8:0]  lim_q, limit_now;
  logic [15:0] agecfg_q;
  status_e     res_status_q;
  logic [IW-1:0] res_where_q;
  logic        out_valid_q;
  logic [2:0]  out_status_q;
  logic [8:0]  out_slot_q;
  logic [9:0]  out_count_q;
  logic [63:0] out_frame_q;
  logic [CmpW-1:0] live_ext, lim_ext;
  logic [WW-1:0]   where_ext;

  // The hash starts at the accepting edge, so it takes the key straight from
  // the input word rather than from key_q.
  ahct_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.hash_start),
    .key_i   (key_i),
    .done_o  (hash_done),
    .hash_o  (hash)
  );

  assign limit_now = (lim_q == 9'd0) ? ENTRY_LIMIT_DEF : lim_q;
  assign live_ext  = CmpW'(live_q);
  assign lim_ext   = CmpW'(limit_now);
  assign where_ext = WW'(res_where_q);
  assign live_dec  = (live_q != '0) ? live_q - CW'(1) : live_q;

  assign wr_en = cmd_i.wr_clr | cmd_i.wr_touch | cmd_i.wr_del_cur | cmd_i.wr_ins |
                 cmd_i.wr_del_pick;
  assign wa    = cmd_i.wr_del_pick ? pick_q : idx_q;

  always_comb begin
    wd = rd_q;
    if (cmd_i.wr_clr) begin
      wd = '{mark: MARK_EMPTY, key: '0, used: '0};
    end else if (cmd_i.wr_del_pick) begin
      wd = '{mark: MARK_DELETED, key: '0, used: '0};
    end else if (cmd_i.wr_ins) begin
      wd = '{mark: MARK_OCCUPIED, key: key_q, used: frame_q};
    end else if (cmd_i.wr_touch) begin
      wd.used = frame_q;
    end else if (cmd_i.wr_del_cur) begin
      wd.mark = MARK_DELETED;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      key_q <= key_i;
    end
    if (cmd_i.load_in) begin
      age_q <= age_limit_i;
    end else if (cmd_i.age_ins) begin
      age_q <= 64'(agecfg_q);
    end
    if (cmd_i.old_init) begin
      oldest_q <= frame_q;
    end else if (cmd_i.old_upd) begin
      oldest_q <= rd_q.used;
      pick_q   <= idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      cnt_q        <= '0;
      live_q       <= '0;
      frame_q      <= '0;
      pick_vld_q   <= 1'b0;
      lim_q        <= ENTRY_LIMIT_RST;
      agecfg_q     <= AGE_LIMIT_RST;
      res_status_q <= ST_DONE;
      res_where_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ENTRY_LIMIT: lim_q    <= cfg_data_i[8:0];
          CFG_AGE_LIMIT:   agecfg_q <= cfg_data_i;
          default:         lim_q    <= lim_q;
        endcase
      end
      if (cmd_i.frame_inc) begin
        frame_q <= frame_q + 64'd1;
      end
      if (cmd_i.idx_zero) begin
        idx_q <= '0;
      end else if (cmd_i.idx_home) begin
        idx_q <= hash[IW-1:0];
        cnt_q <= '0;
      end else if (cmd_i.idx_step) begin
        idx_q <= idx_q + IW'(1);
        cnt_q <= cnt_q + IW'(1);
      end
      if (cmd_i.old_init) begin
        pick_vld_q <= 1'b0;
      end else if (cmd_i.old_upd) begin
        pick_vld_q <= 1'b1;
      end
      if (cmd_i.live_clr) begin
        live_q <= '0;
      end else if (cmd_i.wr_ins) begin
        live_q <= live_q + CW'(1);
      end else if (cmd_i.wr_del_cur || cmd_i.wr_del_pick) begin
        live_q <= live_dec;
      end
      if (cmd_i.load_in) begin
        res_status_q <= ST_DONE;
        res_where_q  <= '0;
      end else if (cmd_i.wr_touch) begin
        res_status_q <= ST_HIT;
        res_where_q  <= idx_q;
      end else if (cmd_i.wr_ins) begin
        res_status_q <= ST_INSERTED;
        res_where_q  <= idx_q;
      end else if (cmd_i.set_nf) begin
        res_status_q <= ST_NOT_FOUND;
      end else if (cmd_i.set_full) begin
        res_status_q <= ST_FULL;
      end
    end
  end

  // Result register: a finished word waits here while the next command runs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= where_ext[8:0];
      out_count_q  <= live_ext[9:0];
      out_frame_q  <= frame_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign slot_index_o   = out_slot_q;
  assign entry_count_o  = out_count_q;
  assign frame_number_o = out_frame_q;

  assign stat_o.hash_done  = hash_done;
  assign stat_o.is_empty   = (rd_q.mark == MARK_EMPTY);
  assign stat_o.is_occ     = (rd_q.mark == MARK_OCCUPIED);
  assign stat_o.key_match  = (rd_q.key == key_q);
  assign stat_o.aged       = ((frame_q - rd_q.used) > age_q);
  assign stat_o.older      = (rd_q.used < oldest_q);
  assign stat_o.idx_last   = (idx_q == '1);
  assign stat_o.cnt_last   = (cnt_q == '1);
  assign stat_o.at_limit   = (live_ext >= lim_ext);
  assign stat_o.over_limit = (live_ext > lim_ext);
  assign stat_o.pick_vld   = pick_vld_q;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

`ifndef NO_ASSERTIONS
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.wr_clr, cmd_i.wr_touch, cmd_i.wr_del_cur, cmd_i.wr_ins,
              cmd_i.wr_del_pick}))
    else $error("more than one slot write source active");
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= CW'(CAPACITY))
    else $error("live count exceeds capacity");
  a_frame_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_q != $past(frame_q) |-> frame_q == $past(frame_q) + 64'd1)
    else $error("frame counter moved by other than one");
`endif

endmodule

// ===== rtl/ahct_ctrl.sv =====
// ----------------------------------------------------------------------------
// ahct_ctrl
// Command sequencer: probes, insert, eviction scans and the clearing pass.
// ----------------------------------------------------------------------------
module ahct_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         command_i,
  input  ahct_pkg::dp_stat_t stat_i,
  output ahct_pkg::dp_cmd_t  cmd_o
);
  import ahct_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_CLR  = 14'b00000000000010,
    S_HASH = 14'b00000000000100,
    S_FRD  = 14'b00000000001000,
    S_FCHK = 14'b00000000010000,
    S_IRD  = 14'b00000000100000,
    S_ICHK = 14'b00000001000000,
    S_ARD  = 14'b00000010000000,
    S_ACHK = 14'b00000100000000,
    S_EVL  = 14'b00001000000000,
    S_BRD  = 14'b00010000000000,
    S_BCHK = 14'b00100000000000,
    S_BDEL = 14'b01000000000000,
    S_FIN  = 14'b10000000000000
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] cmd_q, cmd_d;
  logic       boot_q, boot_d;
  dp_cmd_t    c;
  state_e     ret_state;

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o      = c;

  // Where an eviction pass ends: an insert goes on to its probe.
  assign ret_state = (cmd_q == CMD_INSERT) ? S_IRD : S_FIN;

  always_comb begin
    c       = '0;
    state_d = state_q;
    cmd_d   = cmd_q;
    boot_d  = boot_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          c.load_in = 1'b1;
          cmd_d     = command_i;
          case (command_i)
            CMD_TICK: begin
              c.frame_inc = 1'b1;
              state_d     = S_FIN;
            end
            CMD_LOOKUP, CMD_INSERT, CMD_REMOVE: begin
              c.hash_start = 1'b1;
              state_d      = S_HASH;
            end
            CMD_CLEAR: begin
              c.idx_zero = 1'b1;
              state_d    = S_CLR;
            end
            CMD_EVICT: begin
              c.idx_zero = 1'b1;
              state_d    = S_ARD;
            end
            default: state_d = S_FIN;
          endcase
        end
      end
      S_CLR: begin
        c.wr_clr   = 1'b1;
        c.idx_step = 1'b1;
        if (stat_i.idx_last) begin
          c.live_clr = 1'b1;
          boot_d     = 1'b0;
          state_d    = boot_q ? S_IDLE : S_FIN;
        end
      end
      S_HASH: begin
        if (stat_i.hash_done) begin
          c.idx_home = 1'b1;
          state_d    = S_FRD;
        end
      end
      S_FRD: state_d = S_FCHK;
      S_FCHK: begin
        if (stat_i.is_occ && stat_i.key_match) begin
          if (cmd_q == CMD_REMOVE) begin
            c.wr_del_cur = 1'b1;
          end else begin
            c.wr_touch = 1'b1;
          end
          state_d = S_FIN;
        end else if (stat_i.is_empty || stat_i.cnt_last) begin
          if (cmd_q == CMD_INSERT) begin
            if (stat_i.at_limit) begin
              c.age_ins  = 1'b1;
              c.idx_zero = 1'b1;
              state_d    = S_ARD;
            end else begin
              c.idx_home = 1'b1;
              state_d    = S_IRD;
            end
          end else begin
            c.set_nf = 1'b1;
            state_d  = S_FIN;
          end
        end else begin
          c.idx_step = 1'b1;
          state_d    = S_FRD;
        end
      end
      S_IRD: state_d = S_ICHK;
      S_ICHK: begin
        if (!stat_i.is_occ) begin
          c.wr_ins = 1'b1;
          state_d  = S_FIN;
        end else if (stat_i.cnt_last) begin
          c.set_full = 1'b1;
          state_d    = S_FIN;
        end else begin
          c.idx_step = 1'b1;
          state_d    = S_IRD;
        end
      end
      S_ARD: state_d = S_ACHK;
      S_ACHK: begin
        c.wr_del_cur = stat_i.is_occ && stat_i.aged;
        if (stat_i.idx_last) begin
          state_d = S_EVL;
        end else begin
          c.idx_step = 1'b1;
          state_d    = S_ARD;
        end
      end
      S_EVL: begin
        if (stat_i.over_limit) begin
          c.idx_zero = 1'b1;
          c.old_init = 1'b1;
          state_d    = S_BRD;
        end else begin
          c.idx_home = (cmd_q == CMD_INSERT);
          state_d    = ret_state;
        end
      end
      S_BRD: state_d = S_BCHK;
      S_BCHK: begin
        c.old_upd = stat_i.is_occ && stat_i.older;
        if (stat_i.idx_last) begin
          state_d = S_BDEL;
        end else begin
          c.idx_step = 1'b1;
          state_d    = S_BRD;
        end
      end
      S_BDEL: begin
        if (stat_i.pick_vld) begin
          c.wr_del_pick = 1'b1;
          state_d       = S_EVL;
        end else begin
          c.idx_home = (cmd_q == CMD_INSERT);
          state_d    = ret_state;
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          c.out_load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      cmd_q   <= CMD_TICK;
      boot_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      boot_q  <= boot_d;
    end
  end

endmodule

// ===== rtl/aging_hash_cache_table.sv =====
// ----------------------------------------------------------------------------
// aging_hash_cache_table
// Open-addressing cache of 64-bit keys with per-entry last-used frames.
// ----------------------------------------------------------------------------
// After reset the block clears its slot memory with in_ready_o low;
// configuration writes are taken at any time. One command is worked at a
// time, and one result word is given per command. Lookup, insert and remove
// first hash the key (one 32x32 multiplier, three partial products per
// 64-bit multiply), then probe slot by slot, each slot read and then checked
// through the single read port of the slot memory; an insert that misses
// probes twice (find, then place). A clear writes every slot. Evict aged
// makes an age pass over every slot, then one scan of all slots for each
// oldest-entry drop; an insert at the limit runs this pass before placing its
// key. While a result word waits for out_ready_i, the next command is already
// accepted.
module aging_hash_cache_table #(
  parameter int unsigned CAPACITY = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic [63:0] key_i,
  input  logic [63:0] age_limit_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [8:0]  slot_index_o,
  output logic [9:0]  entry_count_o,
  output logic [63:0] frame_number_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import ahct_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  ahct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  ahct_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .stat_o         (dp_stat),
    .key_i          (key_i),
    .age_limit_i    (age_limit_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .slot_index_o   (slot_index_o),
    .entry_count_o  (entry_count_o),
    .frame_number_o (frame_number_o)
  );

endmodule

// ===== bench/tb_aging_hash_cache_table.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_aging_hash_cache_table
// Self-checking bench for the aging hash cache table. A queue of commands
// feeds a bursty driver, and every accepted word is run through a local model
// of the slot store. A monitor under a random stall pattern compares each
// result word against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_aging_hash_cache_table;
  import ahct_pkg::*;

  localparam int unsigned SLOTS      = 512;
  localparam int unsigned STALL_MAX  = 3000000;
  localparam logic [2:0]  CMD_RSVD6  = 3'd6;
  localparam logic [2:0]  CMD_RSVD7  = 3'd7;
  localparam int unsigned POOL_SIZE  = 48;

  typedef struct {
    logic [2:0]  cmd;
    logic [63:0] key;
    logic [63:0] age;
  } table_cmd_t;

  typedef struct {
    status_e     status;
    logic [8:0]  slot;
    logic [9:0]  count;
    logic [63:0] frame;
  } table_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  command_i;
  logic [63:0] key_i;
  logic [63:0] age_limit_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  status_o;
  logic [8:0]  slot_index_o;
  logic [9:0]  entry_count_o;
  logic [63:0] frame_number_o;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [15:0] cfg_data_i;

  aging_hash_cache_table DUT (.*);

  // Local copy of the table state.
  mark_e       mdl_mark [SLOTS];
  logic [63:0] mdl_key  [SLOTS];
  logic [63:0] mdl_used [SLOTS];
  logic [63:0] mdl_frame;
  int unsigned mdl_live;
  logic [8:0]  mdl_entry_limit;
  logic [15:0] mdl_age_limit;

  table_cmd_t    pending_cmds[$];
  table_result_t expected_results[$];
  logic [63:0]   key_pool[POOL_SIZE];

  int unsigned errors, words_sent, words_checked, hits_seen, full_seen;
  int unsigned burst_left, gap_left, stall_cycles;
  logic [15:0] ready_pattern;
  int unsigned pattern_age;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [8:0] home_of(logic [63:0] k);
    logic [63:0] h;
    h = k;
    h = h ^ (h >> 33);
    h = h * 64'hff51afd7ed558ccd;
    h = h ^ (h >> 33);
    h = h * 64'hc4ceb9fe1a85ec53;
    h = h ^ (h >> 33);
    return h[8:0];
  endfunction

  function automatic int unsigned live_cap();
    return (mdl_entry_limit == 0) ? 256 : mdl_entry_limit;
  endfunction

  // Returns SLOTS when the key is absent.
  function automatic int unsigned locate(logic [63:0] k);
    int unsigned idx;
    idx = home_of(k);
    for (int unsigned n = 0; n < SLOTS; n++) begin
      if (mdl_mark[idx] == MARK_EMPTY) return SLOTS;
      if (mdl_mark[idx] == MARK_OCCUPIED && mdl_key[idx] == k) return idx;
      idx = (idx + 1) % SLOTS;
    end
    return SLOTS;
  endfunction

  task automatic drop_entry(int unsigned i);
    mdl_mark[i] = MARK_DELETED;
    if (mdl_live > 0) mdl_live--;
  endtask

  // Aged entries go first; then the oldest entry from an earlier frame goes
  // until the count fits, lowest slot winning ties.
  task automatic age_out(logic [63:0] age);
    logic [63:0] oldest;
    int unsigned pick;
    for (int unsigned i = 0; i < SLOTS; i++)
      if (mdl_mark[i] == MARK_OCCUPIED && (mdl_frame - mdl_used[i]) > age) drop_entry(i);
    while (mdl_live > live_cap()) begin
      oldest = mdl_frame;
      pick   = SLOTS;
      for (int unsigned i = 0; i < SLOTS; i++)
        if (mdl_mark[i] == MARK_OCCUPIED && mdl_used[i] < oldest) begin
          oldest = mdl_used[i];
          pick   = i;
        end
      if (pick == SLOTS) break;
      drop_entry(pick);
    end
  endtask

  task automatic predict_word(table_cmd_t c);
    table_result_t r;
    int unsigned   s, idx;
    r.status = ST_DONE;
    r.slot   = '0;
    case (c.cmd)
      CMD_TICK: mdl_frame = mdl_frame + 64'd1;
      CMD_LOOKUP, CMD_INSERT: begin
        s = locate(c.key);
        if (s < SLOTS) begin
          mdl_used[s] = mdl_frame;
          r.status    = ST_HIT;
          r.slot      = 9'(s);
        end else if (c.cmd == CMD_LOOKUP) begin
          r.status = ST_NOT_FOUND;
        end else begin
          if (mdl_live >= live_cap()) age_out({48'd0, mdl_age_limit});
          r.status = ST_FULL;
          idx = home_of(c.key);
          for (int unsigned n = 0; n < SLOTS; n++) begin
            if (mdl_mark[idx] != MARK_OCCUPIED) begin
              mdl_mark[idx] = MARK_OCCUPIED;
              mdl_key[idx]  = c.key;
              mdl_used[idx] = mdl_frame;
              mdl_live++;
              r.status = ST_INSERTED;
              r.slot   = 9'(idx);
              break;
            end
            idx = (idx + 1) % SLOTS;
          end
        end
      end
      CMD_REMOVE: begin
        s = locate(c.key);
        if (s < SLOTS) drop_entry(s);
        else r.status = ST_NOT_FOUND;
      end
      CMD_CLEAR: begin
        foreach (mdl_mark[i]) mdl_mark[i] = MARK_EMPTY;
        mdl_live = 0;
      end
      CMD_EVICT: age_out(c.age);
      default: ;
    endcase
    r.count = mdl_live[9:0];
    r.frame = mdl_frame;
    expected_results.push_back(r);
  endtask

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("[%0t] %s mismatch: got %0h, expected %0h", $realtime, field, got, want);
  endtask

  // Driver: bursts of words separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    table_cmd_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_word('{command_i, key_i, age_limit_i});
        words_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          nxt = pending_cmds.pop_front();
          command_i   <= nxt.cmd;
          key_i       <= nxt.key;
          age_limit_i <= nxt.age;
          in_valid_i  <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor with its own stall pattern, a rotating 16-bit ready mask.
  always @(posedge clk_i or negedge rst_ni) begin
    table_result_t e;
    if (!rst_ni) begin
      out_ready_i   <= 1'b0;
      ready_pattern <= 16'hffff;
      pattern_age   <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        words_checked++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("[%0t] result word with nothing expected", $realtime);
        end else begin
          e = expected_results.pop_front();
          if (status_o != e.status) report("status", status_o, e.status);
          if (slot_index_o != e.slot) report("slot_index", slot_index_o, e.slot);
          if (entry_count_o != e.count) report("entry_count", entry_count_o, e.count);
          if (frame_number_o != e.frame) report("frame_number", frame_number_o, e.frame);
          if (e.status == ST_HIT) hits_seen++;
          if (e.status == ST_FULL) full_seen++;
        end
      end
      pattern_age <= pattern_age + 1;
      if (pattern_age % 64 == 63)
        ready_pattern <= ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom());
      else
        ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
      out_ready_i <= ready_pattern[0];
    end
  end

  // Watchdog on cycles with no word moving on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_MAX) begin
        $display("tb_aging_hash_cache_table NOT OK");
        $finish;
      end
    end
  end

  task automatic queue_cmd(logic [2:0] c, logic [63:0] k, logic [63:0] a);
    pending_cmds.push_back('{c, k, a});
  endtask

  // Waits until the table has gone quiet, then writes one register.
  task automatic write_reg(logic idx, logic [15:0] data);
    while (pending_cmds.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_ENTRY_LIMIT) mdl_entry_limit = data[8:0];
    else mdl_age_limit = data;
  endtask

  task automatic queue_random(int unsigned n);
    int unsigned pick;
    logic [63:0] k, a;
    logic [2:0]  c;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12)      c = CMD_TICK;
      else if (pick < 32) c = CMD_LOOKUP;
      else if (pick < 67) c = CMD_INSERT;
      else if (pick < 82) c = CMD_REMOVE;
      else if (pick < 84) c = CMD_CLEAR;
      else if (pick < 95) c = CMD_EVICT;
      else c = pick[0] ? CMD_RSVD6 : CMD_RSVD7;
      k = ($urandom_range(0, 6) == 0) ? {$urandom(), $urandom()}
                                      : key_pool[$urandom_range(0, POOL_SIZE - 1)];
      a = {$urandom(), $urandom()};
      if (c == CMD_EVICT && $urandom_range(0, 5) != 0) a = $urandom_range(0, 12);
      queue_cmd(c, k, a);
    end
  endtask

  initial begin
    errors = 0; words_sent = 0; words_checked = 0; hits_seen = 0; full_seen = 0;
    stall_cycles = 0;
    rst_ni = 1'b0; in_valid_i = 1'b0; out_ready_i = 1'b0;
    command_i = '0; key_i = '0; age_limit_i = '0;
    cfg_we_i = 1'b0; cfg_index_i = CFG_ENTRY_LIMIT; cfg_data_i = '0;
    foreach (mdl_mark[i]) mdl_mark[i] = MARK_EMPTY;
    mdl_frame = '0; mdl_live = 0;
    mdl_entry_limit = 9'd256; mdl_age_limit = 16'd120;
    foreach (key_pool[i]) key_pool[i] = {$urandom(), $urandom()};
    key_pool[0] = 64'd0;
    key_pool[1] = '1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening at reset settings.
    queue_cmd(CMD_TICK, 64'd0, '1);
    queue_cmd(CMD_LOOKUP, key_pool[2], 64'd0);
    queue_cmd(CMD_INSERT, key_pool[2], 64'd0);
    queue_cmd(CMD_INSERT, key_pool[2], 64'd0);
    queue_cmd(CMD_LOOKUP, key_pool[2], 64'd0);
    queue_cmd(CMD_REMOVE, key_pool[2], 64'd0);
    queue_cmd(CMD_REMOVE, key_pool[2], 64'd0);
    queue_cmd(CMD_LOOKUP, key_pool[2], 64'd0);
    queue_cmd(CMD_INSERT, 64'd0, 64'd0);
    queue_cmd(CMD_INSERT, '1, 64'd0);
    queue_cmd(CMD_EVICT, 64'd0, 64'd0);
    queue_cmd(CMD_TICK, 64'd0, 64'd0);
    queue_cmd(CMD_INSERT, key_pool[3], 64'd0);
    queue_cmd(CMD_EVICT, 64'd0, '1);
    queue_cmd(CMD_EVICT, 64'd0, 64'd0);
    queue_cmd(CMD_RSVD6, '1, '1);
    queue_cmd(CMD_RSVD7, 64'd0, 64'd0);
    queue_cmd(CMD_CLEAR, 64'd0, 64'd0);
    queue_cmd(CMD_LOOKUP, 64'd0, 64'd0);

    // Fill every slot within one frame so the table runs full.
    write_reg(CFG_ENTRY_LIMIT, 16'd511);
    write_reg(CFG_AGE_LIMIT, 16'hffff);
    for (int unsigned i = 0; i < SLOTS + 2; i++)
      queue_cmd(CMD_INSERT, {$urandom(), $urandom()}, 64'd0);
    queue_cmd(CMD_LOOKUP, key_pool[4], 64'd0);
    queue_cmd(CMD_TICK, 64'd0, 64'd0);
    queue_cmd(CMD_EVICT, 64'd0, 64'd0);
    queue_cmd(CMD_CLEAR, 64'd0, 64'd0);

    // Upper data bits must be ignored by the 9-bit limit.
    write_reg(CFG_ENTRY_LIMIT, 16'hfe08);
    write_reg(CFG_AGE_LIMIT, 16'd5);
    queue_random(200);
    write_reg(CFG_ENTRY_LIMIT, 16'd1);
    write_reg(CFG_AGE_LIMIT, 16'd0);
    queue_random(100);
    write_reg(CFG_ENTRY_LIMIT, 16'd0);
    write_reg(CFG_AGE_LIMIT, 16'd120);
    queue_random(150);
    write_reg(CFG_ENTRY_LIMIT, 16'd256);
    write_reg(CFG_AGE_LIMIT, 16'hffff);
    queue_random(150);

    while (pending_cmds.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (expected_results.size() != 0) errors++;
    $display("Sent %0d command words, checked %0d result words (%0d hits, %0d table full)",
             words_sent, words_checked, hits_seen, full_seen);
    $display("Entry limits 1/8/256/511 and zero, age limits 0 to 65535; %0d mismatches",
             errors);
    if (errors == 0) begin
      $display("tb_aging_hash_cache_table OK");
    end else begin
      $display("tb_aging_hash_cache_table NOT OK");
    end
    $finish;
  end

endmodule
